FILE: rtl/core/assert_macros.svh
// assertion macros used by the solver
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// a implies b on the same edge
`define ASSERT_IMPL(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("a");
// a implies b on the next edge
`define ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("n");
`endif

FILE: rtl/core/tds_pkg.sv
// types and constants for the tridiagonal solver
// no dependencies
package tds_pkg;
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BOUNDARY = 3'd1;
  localparam logic [2:0] ST_NOTDOM   = 3'd2;
  localparam logic [2:0] ST_ZSUB     = 3'd3;
  localparam logic [2:0] ST_ZSUPER   = 3'd4;
  localparam logic [2:0] ST_SWEEP    = 3'd5;
  localparam logic [2:0] ST_FEW      = 3'd6;
  localparam logic [2:0] ST_MANY     = 3'd7;
  localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
  localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) r = 32'sh7fffffff;
    else if (v < SAT_LO) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // magnitude of a wide signed value
  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    logic [63:0] r;
    r = v[63] ? 64'(-v) : 64'(v);
    return r;
  endfunction
endpackage

FILE: rtl/core/tds_ram.sv
// generic simple dual port ram (one write port, one read port) with registered read
// no dependencies
module tds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/core/tds_div.sv
// restoring divider, one quotient bit per cycle, rounded half away from zero
// uses tds_pkg
module tds_div
  import tds_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [32:0] num,
  input  logic signed [63:0] den,
  output logic               done,
  output logic signed [63:0] quo
);
  localparam int QW = 32 + FRAC_BITS + 2;
  localparam int CW = $clog2(QW + 1);

  logic [QW-1:0] dividend;
  logic [QW:0]   rem;
  logic [63:0]   dmag;
  logic [QW-1:0] q;
  logic [CW-1:0] cnt;
  logic          neg;
  logic          busy;
  logic [QW:0]   trial;
  logic [QW:0]   rem_sh;

  // shift in one bit and try subtraction
  always_comb begin
    rem_sh = {rem[QW-1:0], dividend[QW-1]};
    trial  = rem_sh - (QW+1)'({dmag, 1'b0});
  end

  // sequencer for the quotient bits of (2n<<F + d)/(2d)
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= CW'(QW);
        rem      <= '0;
        q        <= '0;
        dmag     <= mag64(den);
        neg      <= num[32] ^ den[63];
        dividend <= QW'((mag64(64'(num)) << (FRAC_BITS + 1)) + mag64(den));
      end else if (busy) begin
        dividend <= dividend << 1;
        if (!trial[QW]) begin
          rem <= trial;
          q   <= {q[QW-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          q   <= {q[QW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = neg ? -$signed(64'(q)) : $signed(64'(q));
endmodule

FILE: rtl/core/tridiagonal_system_solver.sv
// Channel   Dir  Handshake            Payload
// row       in   row_valid/row_ready  row_sub row_diag row_super row_rhs last_row
// result    out  out_valid/out_ready  solution row_index status determinant last_result
// A row that is not last is taken whenever row_ready is high. A last row starts the
// checks, then the forward sweep on the shared bit-serial divider, then back
// substitution and the output passes.
// Reset is synchronous and resets control and the tolerance (to 1); stores are not cleared.
// The block takes no row from a last row until its final result is taken.
// uses tds_pkg, tds_ram, tds_div, assert_macros.svh
`include "assert_macros.svh"
module tridiagonal_system_solver
  import tds_pkg::*;
#(
  parameter int MAX_ROWS  = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic               row_valid,
  output logic               row_ready,
  input  logic signed [31:0] row_sub,
  input  logic signed [31:0] row_diag,
  input  logic signed [31:0] row_super,
  input  logic signed [31:0] row_rhs,
  input  logic               last_row,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] solution,
  output logic [5:0]         row_index,
  output logic [2:0]         status,
  output logic signed [31:0] determinant,
  output logic               last_result
);
  localparam int AW = 6;
  localparam int DEPTH = 64;
  localparam int CW = 7;

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_CHK   = 4'd1;
  localparam logic [3:0] S_CHKE  = 4'd2;
  localparam logic [3:0] S_SWRD  = 4'd3;
  localparam logic [3:0] S_SWMUL = 4'd4;
  localparam logic [3:0] S_SWD1  = 4'd5;
  localparam logic [3:0] S_SWD2  = 4'd6;
  localparam logic [3:0] S_BKRD  = 4'd7;
  localparam logic [3:0] S_BKEX  = 4'd8;
  localparam logic [3:0] S_OUTRD = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;
  localparam logic [3:0] S_WAIT  = 4'd11;
  localparam logic [3:0] S_ERR   = 4'd12;
  localparam logic [3:0] S_BKW   = 4'd13;
  localparam logic [3:0] S_OUTW  = 4'd14;
  localparam logic [3:0] S_SWW   = 4'd15;

  logic [3:0]    state;
  logic [15:0]   tol;
  logic [CW-1:0] rows_loaded;
  logic [CW-1:0] n;
  logic [AW-1:0] idx;
  logic [AW-1:0] raddr, waddr;
  logic          we_in, we_pf, we_ans;
  logic [31:0]   rd_sub, rd_diag, rd_super, rd_rhs, rd_p, rd_q, rd_x;
  logic [31:0]   w_p, w_q, w_x;
  logic [AW-1:0] pw, xw;
  logic signed [31:0] p_prev, q_prev, x_next, det;
  logic signed [63:0] den;
  logic signed [31:0] num;
  logic signed [31:0] a_cur, c_cur;
  logic          dstart, ddone;
  logic signed [32:0] dnum;
  logic signed [63:0] dquo;
  logic          inner;
  logic          den_bad, p_bad;

  // shared multiplier with rounding
  logic signed [31:0] mx, my;
  logic signed [63:0] mres;
  logic [31:0]        ma, mb;
  logic [63:0]        mprod;
  always_comb begin
    ma    = 32'(mag64(64'(mx)));
    mb    = 32'(mag64(64'(my)));
    mprod = ma * mb;
    mprod = (mprod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    mres  = (mx[31] ^ my[31]) ? -$signed(mprod) : $signed(mprod);
  end

  function automatic logic nz(input logic signed [63:0] v, input logic [15:0] t);
    return mag64(v) < 64'(t);
  endfunction

  assign row_ready = (state == S_LOAD);
  assign we_in = row_valid && row_ready && (rows_loaded < CW'(MAX_ROWS));

  tds_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_sub (.clk, .we(we_in),
    .waddr(rows_loaded[AW-1:0]), .wdata(row_sub), .raddr, .rdata(rd_sub));
  tds_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_diag (.clk, .we(we_in),
    .waddr(rows_loaded[AW-1:0]), .wdata(row_diag), .raddr, .rdata(rd_diag));
  tds_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_super (.clk, .we(we_in),
    .waddr(rows_loaded[AW-1:0]), .wdata(row_super), .raddr, .rdata(rd_super));
  tds_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_rhs (.clk, .we(we_in),
    .waddr(rows_loaded[AW-1:0]), .wdata(row_rhs), .raddr, .rdata(rd_rhs));
  tds_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_pf (.clk, .we(we_pf),
    .waddr(pw), .wdata(w_p), .raddr, .rdata(rd_p));
  tds_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_qf (.clk, .we(we_pf),
    .waddr(pw), .wdata(w_q), .raddr, .rdata(rd_q));
  tds_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ans (.clk, .we(we_ans),
    .waddr(xw), .wdata(w_x), .raddr, .rdata(rd_x));

  tds_div #(.FRAC_BITS(FRAC_BITS)) u_div (.clk, .rst, .start(dstart), .num(dnum),
    .den, .done(ddone), .quo(dquo));

  assign raddr = idx;
  assign waddr = idx;
  assign pw = waddr;
  // row 0 sub and last row super count as zero
  assign a_cur = (idx == '0) ? 32'sd0 : $signed(rd_sub);
  assign c_cur = ({1'b0, idx} == n - 1'b1) ? 32'sd0 : $signed(rd_super);
  assign inner = (idx != '0) && ({1'b0, idx} != n - 1'b1);

  // sweep failure conditions
  assign den_bad = (den == 64'sd0) || nz(den, tol);
  assign p_bad   = mag64(dquo) > (64'd1 << FRAC_BITS);

  // multiplier operand selection per state
  always_comb begin
    mx = a_cur; my = p_prev;
    case (state)
      S_SWMUL: begin mx = a_cur; my = p_prev; end
      S_SWW:   begin mx = a_cur; my = q_prev; end
      S_BKEX:  begin mx = $signed(rd_p); my = x_next; end
      S_BKW:   begin mx = det; my = pivots_det; end
      default: begin mx = a_cur; my = p_prev; end
    endcase
  end

  logic signed [31:0] pcur;
  logic [2:0] err;
  logic signed [31:0] sol_r;
  logic [5:0]  ri_r;
  logic signed [31:0] pivots_det;

  // one-cycle strobes for the divider and the store writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dstart <= 1'b0; we_pf <= 1'b0; we_ans <= 1'b0;
    end else begin
      dstart <= (state == S_SWD1 && !den_bad) ||
                (state == S_SWD2 && ddone && err == ST_OK && !p_bad);
      we_pf  <= (state == S_SWD2) && ddone && (err != ST_OK);
      we_ans <= (state == S_BKEX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD; tol <= 16'd1; rows_loaded <= '0; out_valid <= 1'b0;
    end else begin
      if (cfg_we) tol <= cfg_wdata;
      case (state)
        S_LOAD: begin
          if (row_valid) begin
            if (last_row) begin
              rows_loaded <= '0;
              n <= (rows_loaded <= CW'(MAX_ROWS)) ? rows_loaded + 1'b1 : rows_loaded;
              idx <= rows_loaded[AW-1:0];
              if (rows_loaded >= CW'(MAX_ROWS)) begin err <= ST_MANY; state <= S_ERR; end
              else if (rows_loaded == '0) begin err <= ST_FEW; state <= S_ERR; end
              else state <= S_CHK;
            end else if (rows_loaded <= CW'(MAX_ROWS)) begin
              rows_loaded <= rows_loaded + 1'b1;
            end
          end
        end
        // checks: last row, then row 0, then inner rows in order
        S_CHK: state <= S_CHKE;
        S_CHKE: begin
          if ({1'b0, idx} == n - 1'b1) begin
            if (nz(64'($signed(rd_diag)), tol) || nz(64'(a_cur), tol)) begin
              err <= ST_BOUNDARY; state <= S_ERR;
            end else begin idx <= '0; state <= S_CHK; end
          end else if (idx == '0) begin
            if (nz(64'(c_cur), tol) || nz(64'($signed(rd_diag)), tol)) begin
              err <= ST_BOUNDARY; state <= S_ERR;
            end else if (n == CW'(2)) begin idx <= '0; state <= S_SWRD; end
            else begin idx <= idx + 1'b1; state <= S_CHK; end
          end else begin
            if (inner && mag64(64'($signed(rd_diag))) <
                mag64(64'(a_cur)) + mag64(64'(c_cur))) begin err <= ST_NOTDOM; state <= S_ERR; end
            else if (inner && nz(64'(a_cur), tol)) begin err <= ST_ZSUB; state <= S_ERR; end
            else if (inner && nz(64'(c_cur), tol)) begin err <= ST_ZSUPER; state <= S_ERR; end
            else if ({1'b0, idx} == n - CW'(2)) begin idx <= '0; state <= S_SWRD; end
            else begin idx <= idx + 1'b1; state <= S_CHK; end
          end
        end
        // forward sweep
        S_SWRD: state <= S_SWMUL;
        S_SWMUL: begin
          if (idx == '0) begin
            den <= 64'($signed(rd_diag)); num <= $signed(rd_rhs);
          end else begin
            den <= 64'($signed(rd_diag)) + mres;
          end
          state <= S_SWW;
        end
        S_SWW: begin
          if (idx != '0) num <= sat32(64'($signed(rd_rhs)) - mres);
          state <= S_SWD1;
        end
        S_SWD1: begin
          if (den_bad) begin err <= ST_SWEEP; state <= S_ERR; end
          else begin dnum <= -33'(c_cur); state <= S_SWD2; err <= ST_OK; end
        end
        S_SWD2: begin
          if (ddone) begin
            if (err == ST_OK) begin
              if (p_bad) begin err <= ST_SWEEP; state <= S_ERR; end
              else begin pcur <= dquo[31:0]; dnum <= 33'(num); err <= ST_FEW; end
            end else begin
              p_prev <= pcur; q_prev <= sat32(dquo);
              w_p <= pcur; w_q <= sat32(dquo);
              det <= (idx == '0) ? sat32(den) : det;
              pivots_det <= sat32(den);
              err <= ST_OK;
              state <= S_BKW;
            end
          end
        end
        S_BKW: begin
          if (idx != '0) det <= sat32(mres);
          if ({1'b0, idx} == n - 1'b1) state <= S_BKRD;
          else begin idx <= idx + 1'b1; state <= S_SWRD; end
        end
        // back substitution from the last row down
        S_BKRD: state <= S_BKEX;
        S_BKEX: begin
          if ({1'b0, idx} == n - 1'b1) begin
            x_next <= $signed(rd_q); w_x <= rd_q;
          end else begin
            x_next <= sat32(mres + 64'($signed(rd_q))); w_x <= sat32(mres + 64'($signed(rd_q)));
          end
          xw <= idx;
          if (idx == '0) state <= S_OUTW;
          else begin idx <= idx - 1'b1; state <= S_BKRD; end
        end
        S_OUTW: state <= S_OUTRD;
        S_OUTRD: state <= S_OUT;
        S_OUT: begin
          sol_r <= $signed(rd_x); ri_r <= idx; out_valid <= 1'b1; err <= ST_OK;
          state <= S_WAIT;
        end
        S_ERR: begin
          sol_r <= '0; ri_r <= '0; out_valid <= 1'b1; state <= S_WAIT;
        end
        S_WAIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (err != ST_OK || {1'b0, idx} == n - 1'b1) state <= S_LOAD;
            else begin idx <= idx + 1'b1; state <= S_OUTW; end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  assign solution    = sol_r;
  assign row_index   = ri_r;
  assign status      = (state == S_WAIT) ? err : ST_OK;
  assign last_result = (err != ST_OK) || ({1'b0, ri_r} == n - 1'b1);
  assign determinant = (err == ST_OK && {1'b0, ri_r} == n - 1'b1) ? det : 32'sd0;

  `ASSERT_IMPL(a_no_ready_out, out_valid, !row_ready)
  `ASSERT_IMPL(a_err_index, out_valid && err != ST_OK, ri_r == '0)
  `ASSERT_NEXT(a_drop_valid, out_valid && out_ready, !out_valid)
endmodule
